// ----- src/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons))

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ----- src/bin2dec_pkg.sv -----
// -----------------------------------------------------------------------------
// bin2dec_pkg
// Types, constants and the shift-and-add-3 step of the binary to decimal core.
// -----------------------------------------------------------------------------
package bin2dec_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitWidth    = 4;
  localparam int unsigned BcdWidth      = NumDigits * DigitWidth;
  localparam int unsigned AsciiWidth    = 6;
  localparam int unsigned NumStages     = 8;
  localparam int unsigned StepsPerStage = ValueWidth / NumStages;
  localparam int unsigned CntWidth      = $clog2(NumDigits);
  localparam int unsigned LastIdx       = NumDigits - 1;
  localparam int unsigned MaxLeadDigit  = 4;

  // Upper ASCII bits shared by '0'..'9'.
  localparam logic [AsciiWidth-DigitWidth-1:0] AsciiZeroHi = 2'b11;

  typedef logic [CntWidth-1:0] cnt_t;

  typedef struct packed {
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } dd_t;

  // Apply StepsPerStage double-dabble steps: fix up each digit, then shift.
  function automatic dd_t dabble_steps(dd_t x);
    dd_t r;
    r = x;
    for (int s = 0; s < int'(StepsPerStage); s++) begin
      for (int d = 0; d < int'(NumDigits); d++) begin
        if (r.bcd[d*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
          r.bcd[d*DigitWidth +: DigitWidth] =
            r.bcd[d*DigitWidth +: DigitWidth] + DigitWidth'(3);
        end
      end
      r = r << 1;
    end
    return r;
  endfunction

endpackage

// ----- src/binary_to_decimal_ascii.sv -----
// -----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit unsigned value to ten ASCII decimal digits, most significant first.
// -----------------------------------------------------------------------------
// Each input beat carries one 32-bit unsigned value; the block answers with
// exactly ten output beats, one ASCII character '0'..'9' each, most significant
// digit first, leading zeros kept, and last_o high on the units digit. The
// conversion is a shift-and-add-3 (double dabble) pipeline of eight register
// stages, four bit steps per stage, followed by an output register that
// serializes the 40-bit BCD word one digit per beat. The sustained rate is
// set by the output serializer; the pipeline keeps accepting values while
// it still sends the digits of an earlier one. The next value loads into the
// serializer in the same cycle its predecessor's units digit is taken, so a
// value waiting in the last stage follows without a gap in the stream. Up to
// eight further values wait in the pipeline while the output is stalled;
// in_ready_o drops only when every stage is full.
// The block keeps no state between values and needs no setup after reset.
// -----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import bin2dec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ValueWidth-1:0] value_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AsciiWidth-1:0] ascii_digit_o,
  output logic                  last_o
);

  // Conversion pipeline: stage k holds the value after 4*(k+1) steps.
  dd_t                  stage_q   [NumStages];
  dd_t                  stage_d   [NumStages];
  logic [NumStages-1:0] stage_vld_q;
  logic [NumStages-1:0] stage_vld_in;
  logic [NumStages-1:0] load_en;

  // Output serializer.
  logic                ser_vld_q;
  logic [BcdWidth-1:0] ser_bcd_q;
  cnt_t                ser_cnt_q;
  logic                out_beat;
  logic                ser_load;

  assign out_beat = out_valid_o && out_ready_i;
  // Take a new word when empty or when the units digit leaves this cycle.
  assign ser_load = !ser_vld_q || (out_beat && last_o);

  // Backpressure: a stage may load when empty or when its content moves on.
  always_comb begin
    logic down;
    down = ser_load;
    for (int k = int'(NumStages) - 1; k >= 0; k--) begin
      load_en[k] = !stage_vld_q[k] || down;
      down       = load_en[k];
    end
  end

  assign in_ready_o = load_en[0];

  // Stage inputs: fresh value at the head, previous stage elsewhere.
  always_comb begin
    stage_d[0]      = dabble_steps('{bcd: '0, bin: value_i});
    stage_vld_in[0] = in_valid_i;
    for (int k = 1; k < int'(NumStages); k++) begin
      stage_d[k]      = dabble_steps(stage_q[k-1]);
      stage_vld_in[k] = stage_vld_q[k-1];
    end
  end

  // Valid bits travel with the data; hold a stage when it cannot advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= '0;
    end else begin
      for (int k = 0; k < int'(NumStages); k++) begin
        if (load_en[k]) begin
          stage_vld_q[k] <= stage_vld_in[k];
        end
      end
    end
  end

  // Payload registers load only with a valid beat behind them.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(NumStages); k++) begin
      if (load_en[k] && stage_vld_in[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Serializer control: count digits, drop the word after the units digit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_cnt_q <= '0;
    end else if (ser_load) begin
      ser_vld_q <= stage_vld_q[NumStages-1];
      ser_cnt_q <= '0;
    end else if (out_beat) begin
      ser_cnt_q <= ser_cnt_q + cnt_t'(1);
    end
  end

  // Serializer data: advance one digit per output beat.
  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q <= stage_q[NumStages-1].bcd;
    end else if (out_beat) begin
      ser_bcd_q <= {ser_bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
    end
  end

  assign out_valid_o   = ser_vld_q;
  assign ascii_digit_o = {AsciiZeroHi, ser_bcd_q[BcdWidth-1 -: DigitWidth]};
  assign last_o        = (ser_cnt_q == cnt_t'(LastIdx));

endmodule

// ----- src/bin2dec_checker.sv -----
// -----------------------------------------------------------------------------
// bin2dec_checker
// Port-level checks on the digit stream of binary_to_decimal_ascii.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bin2dec_checker
  import bin2dec_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [AsciiWidth-1:0] ascii_digit_o,
  input logic                  last_o
);

  cnt_t beat_cnt_q;
  logic out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  // Count output beats within one value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
    end else if (out_beat) begin
      beat_cnt_q <= last_o ? '0 : beat_cnt_q + cnt_t'(1);
    end
  end

  `ASSERT_IMPL(a_last_on_tenth, clk_i, rst_ni, out_beat, last_o == (beat_cnt_q == cnt_t'(LastIdx)))
  `ASSERT_IMPL(a_lead_digit_max, clk_i, rst_ni, out_beat && (beat_cnt_q == '0), ascii_digit_o[DigitWidth-1:0] <= DigitWidth'(MaxLeadDigit))
  `ASSERT_IMPL(a_digit_ascii, clk_i, rst_ni, out_valid_o, (ascii_digit_o[AsciiWidth-1:DigitWidth] == AsciiZeroHi) && (ascii_digit_o[DigitWidth-1:0] <= DigitWidth'(9)))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ascii_digit_o) && $stable(last_o))

endmodule

bind binary_to_decimal_ascii bin2dec_checker u_bin2dec_checker (.*);
